// ----- rtl/wsc_pkg.sv -----
package wsc_pkg;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_POSE  = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_ARRIVE_THRESHOLD  = 2'd0,
      CSR_INACTIVE_TICKS    = 2'd1,
      CSR_MAX_LINEAR_SPEED  = 2'd2,
      CSR_MAX_ANGULAR_SPEED = 2'd3
   } csr_index_type;

   localparam logic [30:0] RST_ARRIVE_THRESHOLD  = 31'd6554;
   localparam logic [15:0] RST_INACTIVE_TICKS    = 16'd150;
   localparam logic [14:0] RST_MAX_LINEAR_SPEED  = 15'd2048;
   localparam logic [14:0] RST_MAX_ANGULAR_SPEED = 15'd3072;

   localparam logic signed [16:0] PI_Q12     = 17'sd12868;
   localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
   localparam logic signed [31:0] PI_A       = 32'sd52707178;
   localparam logic signed [31:0] TWO_PI_A   = 32'sd105414356;
   localparam logic signed [27:0] HALF_PI_A  = 28'sd26353589;
   localparam logic [31:0]        ERR_SMALL  = 32'd167772;

   localparam logic [12:0] K_DECAY  = 13'd1638;
   localparam logic [12:0] K_RAMP   = 13'd4506;
   localparam logic [12:0] K_SLOW   = 13'd3072;
   localparam logic signed [33:0] K_STEP   = 34'sd205;
   localparam logic signed [33:0] K_OFFSET = 34'sd410;

   localparam int ATAN_ENTRIES = 24;
   localparam logic [23:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
      24'd1047214, 24'd524117, 24'd262123, 24'd131069,
      24'd65536, 24'd32768, 24'd16384, 24'd8192,
      24'd4096, 24'd2048, 24'd1024, 24'd512,
      24'd256, 24'd128, 24'd64, 24'd32,
      24'd16, 24'd8, 24'd4, 24'd2
   };

   // Product of a value and an unsigned Q1.12 coefficient, with truncation toward zero.
   function automatic logic signed [17:0] mulq(input logic signed [17:0] v,
                                               input logic [12:0] c);
      logic signed [31:0] p;
      logic [31:0] mag;
      logic [31:0] sh;
      p = v * $signed({1'b0, c});
      mag = p[31] ? 32'(-p) : 32'(p);
      sh = mag >> 12;
      return p[31] ? -$signed(18'(sh)) : $signed(18'(sh));
   endfunction

endpackage

// ----- rtl/wsc_req_if.sv -----
interface wsc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic signed [15:0] heading;
   logic               last_waypoint;

   modport source(output valid, kind, coord_x, coord_y, heading, last_waypoint,
                  input ready);
   modport sink(input valid, kind, coord_x, coord_y, heading, last_waypoint,
                output ready);
endinterface

// ----- rtl/wsc_rsp_if.sv -----
interface wsc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] linear_speed;
   logic signed [15:0] angular_speed;
   logic               speed_valid;
   logic               replan_request;
   logic               path_finished;

   modport source(output valid, linear_speed, angular_speed, speed_valid,
                  replan_request, path_finished, input ready);
   modport sink(input valid, linear_speed, angular_speed, speed_valid,
                replan_request, path_finished, output ready);
endinterface

// ----- rtl/wsc_isqrt.sv -----
module wsc_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [64:0] trial;
   logic        take;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign take  = {1'b0, rem_ff} >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (take) begin
            rem_in = rem_ff - trial[63:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ----- rtl/waypoint_steering_controller_top.sv -----
// Waypoint follower for a differential-drive robot. Loads, clears and pose updates
// are handled in the idle state. A control tick while following reads the goal,
// forms the squared distance and squared threshold, and runs the CORDIC bearing
// steps; when a goal is passed the next one is fetched and measured first, and when
// the heading is nearly aligned the 32-step distance square root runs. The shared
// 32x32 multiplier forms the squared distance and threshold one product per cycle;
// the CORDIC bearing iterations run one per cycle; the square root is sequential.
// The block takes no request while a tick is in progress or a result is waiting.
module waypoint_steering_controller_top #(
   parameter int MAX_WAYPOINTS = 64,
   parameter int CORDIC_STEPS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   wsc_req_if.sink     req_chan,
   wsc_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(MAX_WAYPOINTS);
   localparam int CW = $clog2(MAX_WAYPOINTS + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_WAYPOINTS);
   localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_READ  = 13'b0000000000010,
      ST_FETCH = 13'b0000000000100,
      ST_SQX   = 13'b0000000001000,
      ST_SQY   = 13'b0000000010000,
      ST_SQT   = 13'b0000000100000,
      ST_CMP   = 13'b0000001000000,
      ST_CINIT = 13'b0000010000000,
      ST_CSTEP = 13'b0000100000000,
      ST_WRAP  = 13'b0001000000000,
      ST_ROOT  = 13'b0010000000000,
      ST_SPEED = 13'b0100000000000,
      ST_DECAY = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [30:0] thr_ff, thr_in;
   logic [15:0] inact_ff, inact_in;
   logic [14:0] maxlin_ff, maxlin_in;
   logic [14:0] maxang_ff, maxang_in;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] index_ff, index_in;
   logic following_ff, following_in;
   logic loading_ff, loading_in;
   logic timer_run_ff, timer_run_in;
   logic [15:0] timer_ff, timer_in;
   logic signed [31:0] robot_x_ff, robot_x_in;
   logic signed [31:0] robot_y_ff, robot_y_in;
   logic signed [15:0] robot_h_ff, robot_h_in;
   logic signed [15:0] prev_lin_ff, prev_lin_in;
   logic signed [15:0] prev_ang_ff, prev_ang_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic pass2_ff, pass2_in;

   logic [63:0] rd_data_ff;
   logic signed [32:0] dx_ff, dx_in;
   logic signed [32:0] dy_ff, dy_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] thr2_ff, thr2_in;
   logic signed [51:0] cx_ff, cx_in;
   logic signed [51:0] cy_ff, cy_in;
   logic signed [27:0] z_ff, z_in;
   logic [4:0] step_ff, step_in;
   logic signed [31:0] err_ff, err_in;
   logic replan_ff, replan_in;
   logic signed [15:0] lin_ff, lin_in;
   logic signed [15:0] ang_ff, ang_in;
   logic sv_ff, sv_in;
   logic pf_ff, pf_in;

   logic [63:0] goal_mem [MAX_WAYPOINTS];
   logic mem_we;
   logic [AW-1:0] mem_waddr;

   logic req_acc;
   logic csr_wr;
   logic [CW-1:0] load_base, load_count;
   logic load_room;
   logic [CW-1:0] idx_next;
   logic [15:0] tmr_inc;
   logic tmr_hit;
   logic signed [16:0] h_ext, h_wrap;

   logic [32:0] neg_dx, neg_dy;
   logic [31:0] ax, ay, mul_a, mul_b;
   logic [63:0] prod;
   logic [64:0] sq_sum;

   logic signed [51:0] x0, y0, xs, ys;
   logic signed [27:0] atan_val;
   logic signed [31:0] head_a, err_raw, err_wrap;
   logic [31:0] ae_wrap;

   logic isq_start, isq_done;
   logic [31:0] isq_root;

   logic signed [33:0] ae, six_ae, mag1, ramp_a, mag, ang_val;
   logic signed [33:0] dterm, ramp_l, lin_a, lin_b, lin_val;
   logic signed [17:0] abs_pang;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[3:2])
         wsc_pkg::CSR_ARRIVE_THRESHOLD:  csr_prdata = {1'b0, thr_ff};
         wsc_pkg::CSR_INACTIVE_TICKS:    csr_prdata = {16'd0, inact_ff};
         wsc_pkg::CSR_MAX_LINEAR_SPEED:  csr_prdata = {17'd0, maxlin_ff};
         wsc_pkg::CSR_MAX_ANGULAR_SPEED: csr_prdata = {17'd0, maxang_ff};
         default:                        csr_prdata = '0;
      endcase
   end

   always_comb begin
      thr_in    = thr_ff;
      inact_in  = inact_ff;
      maxlin_in = maxlin_ff;
      maxang_in = maxang_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            wsc_pkg::CSR_ARRIVE_THRESHOLD:  thr_in    = csr_pwdata[30:0];
            wsc_pkg::CSR_INACTIVE_TICKS:    inact_in  = csr_pwdata[15:0];
            wsc_pkg::CSR_MAX_LINEAR_SPEED:  maxlin_in = csr_pwdata[14:0];
            wsc_pkg::CSR_MAX_ANGULAR_SPEED: maxang_in = csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   assign load_base  = loading_ff ? count_ff : '0;
   assign load_room  = load_base < MAX_COUNT;
   assign load_count = load_room ? load_base + CW'(1) : load_base;
   assign mem_waddr  = load_base[AW-1:0];
   assign mem_we     = req_acc && (req_chan.kind == wsc_pkg::KIND_LOAD) && load_room;
   assign idx_next   = CW'(index_ff) + CW'(1);

   assign tmr_inc = (timer_ff != 16'hFFFF) ? timer_ff + 16'd1 : timer_ff;
   assign tmr_hit = timer_run_ff && (tmr_inc >= inact_ff);

   assign h_ext  = 17'(req_chan.heading);
   assign h_wrap = (h_ext > wsc_pkg::PI_Q12) ? h_ext - wsc_pkg::TWO_PI_Q12 :
                   (h_ext <= -wsc_pkg::PI_Q12) ? h_ext + wsc_pkg::TWO_PI_Q12 : h_ext;

   assign neg_dx = -dx_ff;
   assign neg_dy = -dy_ff;
   assign ax = dx_ff[32] ? neg_dx[31:0] : dx_ff[31:0];
   assign ay = dy_ff[32] ? neg_dy[31:0] : dy_ff[31:0];

   always_comb begin
      priority if (state_ff == ST_SQX) begin
         mul_a = ax;
         mul_b = ax;
      end else if (state_ff == ST_SQY) begin
         mul_a = ay;
         mul_b = ay;
      end else begin
         mul_a = {1'b0, thr_ff};
         mul_b = {1'b0, thr_ff};
      end
   end

   assign prod   = 64'(mul_a) * 64'(mul_b);
   assign sq_sum = {1'b0, sq_ff} + {1'b0, prod};

   assign x0 = {{3{dx_ff[32]}}, dx_ff, 16'd0};
   assign y0 = {{3{dy_ff[32]}}, dy_ff, 16'd0};
   assign xs = cx_ff >>> step_ff;
   assign ys = cy_ff >>> step_ff;
   assign atan_val = $signed({4'd0, wsc_pkg::ATAN_TABLE[step_ff]});

   assign head_a   = {{4{robot_h_ff[15]}}, robot_h_ff, 12'd0};
   assign err_raw  = head_a - 32'(z_ff);
   assign err_wrap = (err_raw > wsc_pkg::PI_A) ? err_raw - wsc_pkg::TWO_PI_A :
                     (err_raw <= -wsc_pkg::PI_A) ? err_raw + wsc_pkg::TWO_PI_A : err_raw;
   assign ae_wrap  = err_wrap[31] ? 32'(-err_wrap) : 32'(err_wrap);

   assign ae       = err_ff[31] ? -34'(err_ff) : 34'(err_ff);
   assign six_ae   = ((ae <<< 1) + (ae <<< 2)) >>> 12;
   assign mag1     = (six_ae < 34'(maxang_ff)) ? six_ae : 34'(maxang_ff);
   assign abs_pang = prev_ang_ff[15] ? -18'(prev_ang_ff) : 18'(prev_ang_ff);
   assign ramp_a   = 34'(wsc_pkg::mulq(abs_pang, wsc_pkg::K_RAMP)) + wsc_pkg::K_STEP;
   assign mag      = (mag1 < ramp_a) ? mag1 : ramp_a;
   assign ang_val  = (err_ff > 0) ? -mag : ((err_ff < 0) ? mag : '0);

   assign dterm  = 34'(isq_root >> 3) + wsc_pkg::K_OFFSET;
   assign ramp_l = 34'(wsc_pkg::mulq(18'(prev_lin_ff), wsc_pkg::K_RAMP)) + wsc_pkg::K_STEP;
   assign lin_a  = (dterm < 34'(maxlin_ff)) ? dterm : 34'(maxlin_ff);
   assign lin_b  = (ae < 34'(wsc_pkg::ERR_SMALL)) ? ((lin_a < ramp_l) ? lin_a : ramp_l) :
                   34'(wsc_pkg::mulq(18'(prev_lin_ff), wsc_pkg::K_SLOW));
   assign lin_val = (lin_b < -34'sd32768) ? -34'sd32768 : lin_b;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      following_in = following_ff;
      loading_in   = loading_ff;
      timer_run_in = timer_run_ff;
      timer_in     = timer_ff;
      robot_x_in   = robot_x_ff;
      robot_y_in   = robot_y_ff;
      robot_h_in   = robot_h_ff;
      prev_lin_in  = prev_lin_ff;
      prev_ang_in  = prev_ang_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pass2_in     = pass2_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sq_in        = sq_ff;
      thr2_in      = thr2_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      z_in         = z_ff;
      step_in      = step_ff;
      err_in       = err_ff;
      replan_in    = replan_ff;
      lin_in       = lin_ff;
      ang_in       = ang_ff;
      sv_in        = sv_ff;
      pf_in        = pf_ff;
      isq_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_chan.kind)
                  wsc_pkg::KIND_LOAD: begin
                     if (!loading_ff) begin
                        following_in = 1'b0;
                        timer_run_in = 1'b0;
                     end
                     loading_in = 1'b1;
                     count_in   = load_count;
                     if (req_chan.last_waypoint) begin
                        loading_in   = 1'b0;
                        following_in = 1'b1;
                        index_in     = (load_count > CW'(1)) ? AW'(1) : '0;
                     end
                  end
                  wsc_pkg::KIND_CLEAR: begin
                     following_in = 1'b0;
                     loading_in   = 1'b0;
                     if (count_ff != '0) begin
                        timer_run_in = 1'b1;
                        timer_in     = '0;
                     end
                     count_in = '0;
                     index_in = '0;
                  end
                  wsc_pkg::KIND_POSE: begin
                     robot_x_in = req_chan.coord_x;
                     robot_y_in = req_chan.coord_y;
                     robot_h_in = h_wrap[15:0];
                  end
                  wsc_pkg::KIND_TICK: begin
                     if (timer_run_ff) begin
                        timer_in     = tmr_hit ? '0 : tmr_inc;
                        timer_run_in = !tmr_hit;
                     end
                     replan_in = tmr_hit;
                     pass2_in  = 1'b0;
                     pf_in     = 1'b0;
                     if (following_ff) begin
                        state_in = ST_READ;
                     end else if (tmr_hit) begin
                        lin_in       = '0;
                        ang_in       = '0;
                        sv_in        = 1'b0;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: state_in = ST_FETCH;
         ST_FETCH: begin
            dx_in    = 33'($signed(rd_data_ff[63:32])) - 33'(robot_x_ff);
            dy_in    = 33'($signed(rd_data_ff[31:0])) - 33'(robot_y_ff);
            state_in = ST_SQX;
         end
         ST_SQX: begin
            sq_in    = prod;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_in    = sq_sum[64] ? '1 : sq_sum[63:0];
            state_in = ST_SQT;
         end
         ST_SQT: begin
            thr2_in  = prod;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            priority if (!pass2_ff && (sq_ff < thr2_ff)) begin
               if (idx_next >= count_ff) begin
                  index_in     = '0;
                  following_in = 1'b0;
                  count_in     = '0;
                  pf_in        = 1'b1;
                  state_in     = ST_DECAY;
               end else begin
                  index_in = idx_next[AW-1:0];
                  pass2_in = 1'b1;
                  state_in = ST_READ;
               end
            end else if (sq_ff <= thr2_ff) begin
               lin_in       = '0;
               ang_in       = '0;
               prev_lin_in  = '0;
               prev_ang_in  = '0;
               sv_in        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_CINIT;
            end
         end
         ST_CINIT: begin
            step_in = '0;
            if (x0 < 0) begin
               if (y0 >= 0) begin
                  cx_in = y0;
                  cy_in = -x0;
                  z_in  = wsc_pkg::HALF_PI_A;
               end else begin
                  cx_in = -y0;
                  cy_in = x0;
                  z_in  = -wsc_pkg::HALF_PI_A;
               end
            end else begin
               cx_in = x0;
               cy_in = y0;
               z_in  = '0;
            end
            state_in = ST_CSTEP;
         end
         ST_CSTEP: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in  = z_ff + atan_val;
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in  = z_ff - atan_val;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            err_in = err_wrap;
            if (ae_wrap < wsc_pkg::ERR_SMALL) begin
               isq_start = 1'b1;
               state_in  = ST_ROOT;
            end else begin
               state_in = ST_SPEED;
            end
         end
         ST_ROOT: begin
            if (isq_done) begin
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            lin_in       = lin_val[15:0];
            ang_in       = ang_val[15:0];
            prev_lin_in  = lin_val[15:0];
            prev_ang_in  = ang_val[15:0];
            sv_in        = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_DECAY: begin
            lin_in       = 16'(wsc_pkg::mulq(18'(prev_lin_ff), wsc_pkg::K_DECAY));
            ang_in       = 16'(wsc_pkg::mulq(18'(prev_ang_ff), wsc_pkg::K_DECAY));
            prev_lin_in  = 16'(wsc_pkg::mulq(18'(prev_lin_ff), wsc_pkg::K_DECAY));
            prev_ang_in  = 16'(wsc_pkg::mulq(18'(prev_ang_ff), wsc_pkg::K_DECAY));
            sv_in        = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= wsc_pkg::RST_ARRIVE_THRESHOLD;
         inact_ff     <= wsc_pkg::RST_INACTIVE_TICKS;
         maxlin_ff    <= wsc_pkg::RST_MAX_LINEAR_SPEED;
         maxang_ff    <= wsc_pkg::RST_MAX_ANGULAR_SPEED;
         count_ff     <= '0;
         index_ff     <= '0;
         following_ff <= 1'b0;
         loading_ff   <= 1'b0;
         timer_run_ff <= 1'b0;
         timer_ff     <= '0;
         robot_x_ff   <= '0;
         robot_y_ff   <= '0;
         robot_h_ff   <= '0;
         prev_lin_ff  <= '0;
         prev_ang_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pass2_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         inact_ff     <= inact_in;
         maxlin_ff    <= maxlin_in;
         maxang_ff    <= maxang_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         following_ff <= following_in;
         loading_ff   <= loading_in;
         timer_run_ff <= timer_run_in;
         timer_ff     <= timer_in;
         robot_x_ff   <= robot_x_in;
         robot_y_ff   <= robot_y_in;
         robot_h_ff   <= robot_h_in;
         prev_lin_ff  <= prev_lin_in;
         prev_ang_ff  <= prev_ang_in;
         rsp_valid_ff <= rsp_valid_in;
         pass2_ff     <= pass2_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sq_ff     <= sq_in;
      thr2_ff   <= thr2_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      z_ff      <= z_in;
      step_ff   <= step_in;
      err_ff    <= err_in;
      replan_ff <= replan_in;
      lin_ff    <= lin_in;
      ang_ff    <= ang_in;
      sv_ff     <= sv_in;
      pf_ff     <= pf_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         goal_mem[mem_waddr] <= {req_chan.coord_x, req_chan.coord_y};
      end
      rd_data_ff <= goal_mem[index_ff];
   end

   wsc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (isq_start),
      .radicand (sq_ff),
      .done     (isq_done),
      .root     (isq_root)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.linear_speed   = lin_ff;
   assign rsp_chan.angular_speed  = ang_ff;
   assign rsp_chan.speed_valid    = sv_ff;
   assign rsp_chan.replan_request = replan_ff;
   assign rsp_chan.path_finished  = pf_ff;

   a_index_in_path: assert property (@(posedge clock) disable iff (reset)
      following_ff |-> (CW'(index_ff) < count_ff))
      else $error("active index beyond the loaded path");

   a_load_follow_excl: assert property (@(posedge clock) disable iff (reset)
      !(loading_ff && following_ff))
      else $error("loading and following at the same time");

   a_quiet_speeds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !sv_ff) |-> (lin_ff == 16'sd0 && ang_ff == 16'sd0))
      else $error("speeds published without a velocity command");

   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pf_ff) |-> (!following_ff && count_ff == '0))
      else $error("path finished while still following");

   a_cordic_right_half: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CSTEP) |-> !cx_ff[51])
      else $error("CORDIC vector left the right half plane");

endmodule
